[rtl/rfp_pkg.sv]
// Shared constants, types and the CRC-8 step for the range frame parser.
package rfp_pkg;

  localparam int FRAME_BYTES_DEF  = 19;
  localparam int NUM_CHANNELS_DEF = 8;

  localparam logic [7:0]  START_BYTE        = 8'h54;
  localparam logic [7:0]  CRC_POLY          = 8'h07;
  localparam logic [15:0] FALLBACK_RANGE    = 16'd10000;
  localparam logic [15:0] FALLBACK_CRC      = 16'd10500;
  localparam logic [15:0] FALLBACK_OVERFLOW = 16'd11000;

  localparam logic [15:0] RST_RANGE_MIN = 16'd200;
  localparam logic [15:0] RST_RANGE_MAX = 16'd14000;
  localparam logic [2:0]  RST_LEFT_CH   = 3'd2;
  localparam logic [2:0]  RST_RIGHT_CH  = 3'd7;

  typedef enum logic [1:0] {
    REG_RANGE_MIN = 2'd0,
    REG_RANGE_MAX = 2'd1,
    REG_LEFT_CH   = 2'd2,
    REG_RIGHT_CH  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC      = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic en;
    logic hi;
  } store_wr_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

  localparam logic [7:0] CRC_AFTER_START = crc8_step(8'h00, START_BYTE);

endpackage

[rtl/ranger_frame_parser_crc8_unit.sv]
// Top level of the range sensor frame parser with CRC-8 check.
//
// Usage:
//   s_axis carries one received serial byte per transaction in tdata[7:0].
//   The byte 'T' starts a frame. 'T' arriving with a full frame held checks
//   the CRC-8 (poly 0x07) and emits one result transaction on m_axis; a
//   non-'T' byte arriving with a full frame held emits an overflow result.
//   Other bytes emit nothing.
//   m_axis tdata: left_mm[15:0], right_mm[31:16];
//   m_axis tuser: status[1:0], left_valid[2], right_valid[3].
//   The APB port holds the window limits and the two channel selects.
// Timing:
//   One byte per cycle sustained while the receiver keeps up. The check stage
//   loads at the edge that accepts the byte that causes a result, its channel
//   words come from the registered store read, and the output register loads
//   from the check stage once it is empty or being read.
// Reset clears the byte count, CRC, pipeline valids and registers to their
//   defaults. When the receiver stalls, the output register and the check
//   stage hold, and s_axis_tready drops only when both are occupied.
module ranger_frame_parser_crc8_unit #(
  parameter int FRAME_BYTES  = rfp_pkg::FRAME_BYTES_DEF,
  parameter int NUM_CHANNELS = rfp_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // left_mm[15:0], right_mm[31:16]
  output logic [3:0]  m_axis_tuser,   // status[1:0], left_valid[2], right_valid[3]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rfp_pkg::*;

  localparam int FIT_WORDS = (FRAME_BYTES - 3) / 2;
  localparam int WORDS_A   = (FIT_WORDS < NUM_CHANNELS) ? FIT_WORDS : NUM_CHANNELS;
  localparam int WORDS     = (WORDS_A < 8) ? WORDS_A : 8;
  localparam int DEPTH     = (WORDS > 1) ? WORDS : 1;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(FRAME_BYTES + 1);

  localparam logic [CW-1:0] CNT_FULL  = CW'(FRAME_BYTES);
  localparam logic [CW-1:0] CNT_CRC   = CW'(FRAME_BYTES - 1);
  localparam logic [CW-1:0] WR_START  = CW'(2);
  localparam logic [CW-1:0] WR_END    = CW'(2 + 2 * WORDS);
  localparam logic [3:0]    WORDS_LIM = 4'(WORDS);

  // configuration
  logic [15:0] range_min_q, range_max_q;
  logic [2:0]  left_ch_q, right_ch_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q <= RST_RANGE_MIN;
      range_max_q <= RST_RANGE_MAX;
      left_ch_q   <= RST_LEFT_CH;
      right_ch_q  <= RST_RIGHT_CH;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_RANGE_MIN: range_min_q <= pwdata[15:0];
        REG_RANGE_MAX: range_max_q <= pwdata[15:0];
        REG_LEFT_CH:   left_ch_q   <= pwdata[2:0];
        REG_RIGHT_CH:  right_ch_q  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3:2]))
      REG_RANGE_MIN: prdata = {16'd0, range_min_q};
      REG_RANGE_MAX: prdata = {16'd0, range_max_q};
      REG_LEFT_CH:   prdata = {29'd0, left_ch_q};
      REG_RIGHT_CH:  prdata = {29'd0, right_ch_q};
      default:       prdata = 32'd0;
    endcase
  end

  // handshake and pipeline control
  logic s1_valid_q, s1_ovf_q, s1_crc_ok_q;
  logic m_valid_q;
  logic out_ld, s1_adv, in_acc;

  assign out_ld        = !m_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_ld;
  assign s_axis_tready = !s1_valid_q || out_ld;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // frame state
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    crc_q, crc_d;
  logic [7:0]    crc_byte_q;
  logic          is_start, full, hit, hit_ovf;

  assign is_start = (s_axis_tdata == START_BYTE);
  assign full     = (count_q == CNT_FULL);
  assign hit      = in_acc && full;
  assign hit_ovf  = !is_start;

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    if (in_acc) begin
      if (is_start) begin
        count_d = CW'(1);
        crc_d   = CRC_AFTER_START;
      end else if (!full) begin
        count_d = count_q + CW'(1);
        if (count_q < CNT_CRC) begin
          crc_d = crc8_step(crc_q, s_axis_tdata);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q   <= '0;
    end else begin
      count_q <= count_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !is_start && (count_q == CNT_CRC)) begin
      crc_byte_q <= s_axis_tdata;
    end
  end

  // channel store
  store_wr_t     st_wr;
  logic [CW-1:0] wr_off;
  logic [AW-1:0] wr_addr, rd_addr_l, rd_addr_r;
  logic          ch_ok_l, ch_ok_r;
  logic [15:0]   rd_l, rd_r;

  assign wr_off   = count_q - WR_START;
  assign wr_addr  = wr_off[AW:1];
  assign st_wr.en = in_acc && !is_start && (count_q >= WR_START) && (count_q < WR_END);
  assign st_wr.hi = !count_q[0];

  assign ch_ok_l   = ({1'b0, left_ch_q} < WORDS_LIM);
  assign ch_ok_r   = ({1'b0, right_ch_q} < WORDS_LIM);
  assign rd_addr_l = ch_ok_l ? left_ch_q[AW-1:0] : '0;
  assign rd_addr_r = ch_ok_r ? right_ch_q[AW-1:0] : '0;

  rfp_chan_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_i       (st_wr),
    .wr_addr_i  (wr_addr),
    .wr_byte_i  (s_axis_tdata),
    .rd_addr_l_i(rd_addr_l),
    .rd_addr_r_i(rd_addr_r),
    .rd_l_o     (rd_l),
    .rd_r_o     (rd_r)
  );

  // check stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (hit) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      s1_ovf_q    <= hit_ovf;
      s1_crc_ok_q <= (crc_q == crc_byte_q);
    end
  end

  // result
  logic [15:0] raw_l, raw_r, left_d, right_d;
  logic        in_l, in_r, lv_d, rv_d;
  status_e     status_d;
  logic [15:0] left_q, right_q;
  logic        lv_q, rv_q;
  status_e     status_q;

  assign raw_l = ch_ok_l ? rd_l : 16'd0;
  assign raw_r = ch_ok_r ? rd_r : 16'd0;
  assign in_l  = (raw_l > range_min_q) && (raw_l < range_max_q);
  assign in_r  = (raw_r > range_min_q) && (raw_r < range_max_q);

  always_comb begin
    if (s1_ovf_q) begin
      left_d   = FALLBACK_OVERFLOW;
      right_d  = FALLBACK_OVERFLOW;
      status_d = ST_OVERFLOW;
      lv_d     = 1'b0;
      rv_d     = 1'b0;
    end else if (!s1_crc_ok_q) begin
      left_d   = FALLBACK_CRC;
      right_d  = FALLBACK_CRC;
      status_d = ST_CRC;
      lv_d     = 1'b0;
      rv_d     = 1'b0;
    end else begin
      left_d   = in_l ? raw_l : FALLBACK_RANGE;
      right_d  = in_r ? raw_r : FALLBACK_RANGE;
      status_d = ST_OK;
      lv_d     = in_l;
      rv_d     = in_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ld) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_q   <= left_d;
      right_q  <= right_d;
      status_q <= status_d;
      lv_q     <= lv_d;
      rv_q     <= rv_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {right_q, left_q};
  assign m_axis_tuser  = {rv_q, lv_q, status_q};

endmodule

[rtl/rfp_chan_store.sv]
// Channel word store: big-endian 16-bit channel readings with two registered read ports.
module rfp_chan_store #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic               clk_i,
  input  rfp_pkg::store_wr_t wr_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  logic [7:0]         wr_byte_i,
  input  logic [AW-1:0]      rd_addr_l_i,
  input  logic [AW-1:0]      rd_addr_r_i,
  output logic [15:0]        rd_l_o,
  output logic [15:0]        rd_r_o
);
  import rfp_pkg::*;

  logic [7:0]  mem_hi [DEPTH];
  logic [7:0]  mem_lo [DEPTH];
  logic [15:0] rd_l_q;
  logic [15:0] rd_r_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.hi) begin
      mem_hi[wr_addr_i] <= wr_byte_i;
    end
    if (wr_i.en && !wr_i.hi) begin
      mem_lo[wr_addr_i] <= wr_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_l_q <= {mem_hi[rd_addr_l_i], mem_lo[rd_addr_l_i]};
    rd_r_q <= {mem_hi[rd_addr_r_i], mem_lo[rd_addr_r_i]};
  end

  assign rd_l_o = rd_l_q;
  assign rd_r_o = rd_r_q;

endmodule

[bench/range_frame_sb_pkg.sv]
// Scoreboard for the range frame parser: byte-level predictor and result checker.
`timescale 1ns / 100ps
package range_frame_sb_pkg;
  import rfp_pkg::*;

  localparam int HELD_MAX = FRAME_BYTES_DEF;
  localparam int CHANNELS = NUM_CHANNELS_DEF;

  typedef struct packed {
    logic [15:0] left_mm;
    logic [15:0] right_mm;
    status_e     status;
    logic        left_valid;
    logic        right_valid;
  } range_result_t;

  class range_frame_scoreboard;
    logic [7:0]    held [HELD_MAX];
    int unsigned   held_count;
    logic [7:0]    crc_acc;
    logic [15:0]   win_lo;
    logic [15:0]   win_hi;
    logic [2:0]    left_sel;
    logic [2:0]    right_sel;
    range_result_t awaited [$];
    int unsigned   errors;
    int unsigned   bytes_in;
    int unsigned   results_in;
    int unsigned   frames_ok;
    int unsigned   frames_bad_crc;
    int unsigned   overflows;
    int unsigned   in_window;

    function new();
      foreach (held[i]) held[i] = 8'h00;
      held_count     = 0;
      crc_acc        = 8'h00;
      win_lo         = RST_RANGE_MIN;
      win_hi         = RST_RANGE_MAX;
      left_sel       = RST_LEFT_CH;
      right_sel      = RST_RIGHT_CH;
      errors         = 0;
      bytes_in       = 0;
      results_in     = 0;
      frames_ok      = 0;
      frames_bad_crc = 0;
      overflows      = 0;
      in_window      = 0;
    endfunction

    static function logic [7:0] crc_next(logic [7:0] crc, logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      repeat (8) v = {v[6:0], 1'b0} ^ (v[7] ? CRC_POLY : 8'h00);
      return v;
    endfunction

    function void set_register(reg_idx_e idx, logic [31:0] value);
      case (idx)
        REG_RANGE_MIN: win_lo    = value[15:0];
        REG_RANGE_MAX: win_hi    = value[15:0];
        REG_LEFT_CH:   left_sel  = value[2:0];
        REG_RIGHT_CH:  right_sel = value[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned predicted();
      return frames_ok + frames_bad_crc + overflows;
    endfunction

    // Channel c sits big-endian at bytes 2+2c and 3+2c; unreachable channels read as 0.
    function void reading(logic [2:0] sel, output logic [15:0] mm, output logic ok);
      int unsigned hi_idx;
      logic [15:0] raw;
      hi_idx = 2 + 2 * sel;
      if (sel >= CHANNELS || hi_idx + 1 >= HELD_MAX - 1) raw = 16'h0000;
      else raw = {held[hi_idx], held[hi_idx + 1]};
      ok = (raw > win_lo) && (raw < win_hi);
      mm = ok ? raw : FALLBACK_RANGE;
    endfunction

    function void note_byte(logic [7:0] b);
      range_result_t r;
      bytes_in++;
      if (b != START_BYTE) begin
        if (held_count < HELD_MAX) begin
          held[held_count] = b;
          if (held_count < HELD_MAX - 1) crc_acc = crc_next(crc_acc, b);
          held_count++;
        end else begin
          r = '{FALLBACK_OVERFLOW, FALLBACK_OVERFLOW, ST_OVERFLOW, 1'b0, 1'b0};
          overflows++;
          awaited.push_back(r);
        end
        return;
      end
      if (held_count == HELD_MAX) begin
        if (crc_acc == held[HELD_MAX - 1]) begin
          reading(left_sel, r.left_mm, r.left_valid);
          reading(right_sel, r.right_mm, r.right_valid);
          r.status = ST_OK;
          in_window += r.left_valid + r.right_valid;
          frames_ok++;
        end else begin
          r = '{FALLBACK_CRC, FALLBACK_CRC, ST_CRC, 1'b0, 1'b0};
          frames_bad_crc++;
        end
        awaited.push_back(r);
      end
      held[0]    = START_BYTE;
      held_count = 1;
      crc_acc    = crc_next(8'h00, START_BYTE);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] ERROR %s", $time, msg);
    endtask

    task check_result(logic [31:0] data, logic [3:0] user);
      range_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: tdata=%h tuser=%h", data, user));
        return;
      end
      want = awaited.pop_front();
      results_in++;
      if (data[15:0] != want.left_mm)
        report($sformatf("left_mm got %0d want %0d", data[15:0], want.left_mm));
      if (data[31:16] != want.right_mm)
        report($sformatf("right_mm got %0d want %0d", data[31:16], want.right_mm));
      if (user[1:0] != want.status)
        report($sformatf("status got %0d want %s", user[1:0], want.status.name()));
      if (user[2] != want.left_valid)
        report($sformatf("left_valid got %b want %b", user[2], want.left_valid));
      if (user[3] != want.right_valid)
        report($sformatf("right_valid got %b want %b", user[3], want.right_valid));
    endtask
  endclass

endpackage

[bench/ranger_frame_parser_crc8_unit_tb.sv]
// Testbench for the range frame parser: framed byte streams checked by a scoreboard.
`timescale 1ns / 100ps
module ranger_frame_parser_crc8_unit_tb;
  import rfp_pkg::*;
  import range_frame_sb_pkg::*;

  localparam int STALL_LIMIT   = 5000;
  localparam int ITEM_TARGET   = 450;
  localparam int DIRECTED      = 23;
  localparam int PHASES        = 6;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 6;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tready = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = 4'h0;
  logic [31:0] pwdata        = 32'h0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic [31:0] prdata;
  logic        pready;

  range_frame_scoreboard frame_checker;
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 60;
  bit          hold_off_req  = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;
  logic [7:0]  frame_buf [HELD_MAX];
  logic [15:0] chan_mm [CHANNELS];

  ranger_frame_parser_crc8_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) frame_checker.note_byte(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      frame_checker.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_left    = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frame_checker.set_register(idx, value);
    @(posedge clk_i);
  endtask

  // Also covers bytes that leave no result but may still be in flight.
  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (frame_checker.awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input int p);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [2:0]  lch;
    logic [2:0]  rch;
    case (p)
      0: begin lo = 16'h0000; hi = 16'hFFFF; lch = 3'd0; rch = 3'd7; end
      1: begin lo = 16'hFFFF; hi = 16'h0000; lch = 3'd7; rch = 3'd0; end
      2: begin lo = 16'd1000; hi = 16'd1001; lch = 3'd3; rch = 3'd3; end
      3: begin lo = RST_RANGE_MIN; hi = RST_RANGE_MAX; lch = 3'd1; rch = 3'd6; end
      default: begin
        lo  = 16'($urandom_range(0, 20000));
        hi  = 16'($urandom_range(lo, 65535));
        lch = 3'($urandom_range(0, 7));
        rch = 3'($urandom_range(0, 7));
      end
    endcase
    apb_write(REG_RANGE_MIN, {16'h0000, lo});
    apb_write(REG_RANGE_MAX, {16'h0000, hi});
    apb_write(REG_LEFT_CH, {29'h0, lch});
    apb_write(REG_RIGHT_CH, {29'h0, rch});
  endtask

  function automatic logic [15:0] pick_distance();
    logic [15:0] lo;
    logic [15:0] hi;
    lo = frame_checker.win_lo;
    hi = frame_checker.win_hi;
    case ($urandom_range(0, 9))
      0: return lo;
      1: return lo + 16'd1;
      2: return hi - 16'd1;
      3: return hi;
      4: return 16'h0000;
      5: return 16'hFFFF;
      6, 7: return 16'($urandom_range(lo, hi));
      default: return 16'($urandom());
    endcase
  endfunction

  // Start bytes inside the payload would restart the frame, so they are nudged away.
  task automatic build_frame(input logic [7:0] first, input logic [7:0] second,
                             input bit corrupt);
    logic [7:0] crc;
    logic [7:0] bad;
    frame_buf[0] = first;
    frame_buf[1] = (second == START_BYTE) ? 8'h55 : second;
    for (int c = 0; c < CHANNELS; c++) begin
      frame_buf[2 + 2 * c] = chan_mm[c][15:8];
      frame_buf[3 + 2 * c] = chan_mm[c][7:0];
    end
    for (int i = 2; i < HELD_MAX - 1; i++)
      if (frame_buf[i] == START_BYTE) frame_buf[i] = 8'h55;
    do begin
      crc = 8'h00;
      for (int i = 0; i < HELD_MAX - 1; i++)
        crc = range_frame_scoreboard::crc_next(crc, frame_buf[i]);
      if (crc == START_BYTE)
        frame_buf[1] = (frame_buf[1] == 8'h53) ? 8'h55 : frame_buf[1] + 8'd1;
    end while (crc == START_BYTE);
    bad = crc;
    while (corrupt && (bad == crc || bad == START_BYTE)) bad = 8'($urandom_range(0, 255));
    frame_buf[HELD_MAX - 1] = bad;
  endtask

  task automatic send_frame_buf();
    foreach (frame_buf[i]) send_byte(frame_buf[i]);
  endtask

  task automatic send_overflow_bytes(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      send_byte((b == START_BYTE) ? ~b : b);
    end
  endtask

  task automatic send_random_frame();
    int unsigned roll;
    int unsigned extra;
    logic [7:0]  b;
    roll = $urandom_range(0, 99);
    if (roll >= 85) begin
      if (roll < 93) begin
        send_byte(START_BYTE);
        extra = $urandom_range(0, 16);
      end else begin
        extra = $urandom_range(1, 6);
      end
      repeat (extra) begin
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) b = START_BYTE;
        send_byte(b);
      end
      return;
    end
    foreach (chan_mm[c]) chan_mm[c] = pick_distance();
    build_frame(START_BYTE, 8'($urandom_range(0, 255)), roll >= 62 && roll < 75);
    send_frame_buf();
    if (roll >= 75) send_overflow_bytes($urandom_range(1, 4));
  endtask

  // Receiver stalls while overflow bytes keep coming, so both stages fill.
  task automatic flood_while_held();
    hold_off_req = 1'b1;
    foreach (chan_mm[c]) chan_mm[c] = pick_distance();
    build_frame(START_BYTE, 8'h3C, 1'b0);
    send_frame_buf();
    send_overflow_bytes(8);
  endtask

  initial begin
    frame_checker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first frame straight after reset, no leading start byte
    chan_mm = '{16'h0000, 16'hFFFF, 16'd201, 16'd200, 16'd14000, 16'd13999,
                16'h5AA5, 16'd13999};
    build_frame(8'h00, 8'hFF, 1'b0);
    send_frame_buf();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(START_BYTE);
    send_byte(START_BYTE);

    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      case (p / 2)
        0:       begin send_idle_pct = 11; recv_idle_pct = 60; end
        1:       begin send_idle_pct = 60; recv_idle_pct = 11; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      configure(p);
      if (p == 1 || p == 4) flood_while_held();
      while (frame_checker.bytes_in < DIRECTED + ITEM_TARGET * (p + 1) / PHASES ||
             frame_checker.predicted() < 8 * (p + 1))
        send_random_frame();
    end

    drain_and_settle();
    $display("Covered %0d bytes and %0d results: %0d frames passed the CRC, %0d failed it,",
             frame_checker.bytes_in, frame_checker.results_in, frame_checker.frames_ok,
             frame_checker.frames_bad_crc);
    $display("%0d overflow reports, %0d in-window readings over %0d register settings.",
             frame_checker.overflows, frame_checker.in_window, PHASES + 1);
    if (frame_checker.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[ranger_frame_parser_crc8_unit.f]
rtl/rfp_pkg.sv
rtl/rfp_chan_store.sv
rtl/ranger_frame_parser_crc8_unit.sv
bench/range_frame_sb_pkg.sv
bench/ranger_frame_parser_crc8_unit_tb.sv
